// File: rtl/vlcp_pkg.sv
package vlcp_pkg;

  localparam int BYTE_BITS = 8;
  localparam int MODE_W    = 2;
  localparam int SYM_W     = 8;
  localparam int LEN_W     = 6;
  localparam int CODE_W    = 32;
  localparam int TOTAL_W   = 32;
  localparam int PEND_W    = BYTE_BITS - 1;
  localparam int PCNT_W    = 3;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int MAX_CODE_BITS_DEF = 32;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_EMIT,
    ST_FLUSH
  } vlcp_state_t;

endpackage

// File: rtl/variable_length_code_packer.sv
// Load request: written into the table while it has room, no result.
// Encode request: table scan from the newest entry down, one compare per cycle,
//   then the output bytes, one per cycle while the output is free; leftover bits
//   stay pending in the accumulator.
// Flush request: result registered from ST_FLUSH once the output is free.
// Reset clears control, fill count and bit accumulator; table contents stay undefined.
module variable_length_code_packer #(
  parameter int TABLE_ENTRIES = vlcp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_BITS = vlcp_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vlcp_pkg::MODE_W-1:0]   in_mode,
  input  logic [vlcp_pkg::SYM_W-1:0]    in_symbol,
  input  logic [vlcp_pkg::LEN_W-1:0]    in_code_length,
  input  logic [vlcp_pkg::CODE_W-1:0]   in_code_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vlcp_pkg::BYTE_BITS-1:0] out_byte,
  output logic                          out_has_byte,
  output logic [vlcp_pkg::TOTAL_W-1:0]  out_total_bits,
  output logic                          out_last
);
  import vlcp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LOAD_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W   = SYM_W + LEN_W + CODE_W;
  localparam int ACC_W   = PEND_W + LEN_CAP;
  localparam int CNT_W   = $clog2(ACC_W + 1);

  vlcp_state_t state_r, state_nxt;

  logic [ENT_W-1:0]   mem [TABLE_ENTRIES];
  logic [ENT_W-1:0]   rd_data_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;

  logic [LOAD_W-1:0]  loaded_r, loaded_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   idx_r;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PEND_W-1:0]  pend_val_r, pend_val_nxt;
  logic [PCNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [TOTAL_W-1:0] bit_total_r, bit_total_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0] out_byte_r, out_byte_nxt;
  logic                 out_has_r, out_has_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_last_r, out_last_nxt;

  logic               in_acc;
  logic               out_free;
  logic [SYM_W-1:0]   rd_sym;
  logic [LEN_W-1:0]   rd_len;
  logic [CODE_W-1:0]  rd_code;
  logic [LEN_W-1:0]   load_len;
  logic [LOAD_W-1:0]  loaded_m1;
  logic [TOTAL_W:0]   total_sum;
  logic [CNT_W-1:0]   emit_shamt;
  logic [ACC_W-1:0]   emit_shifted;
  logic [BYTE_BITS-1:0] flush_byte;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign rd_sym  = rd_data_r[ENT_W-1 -: SYM_W];
  assign rd_len  = rd_data_r[CODE_W +: LEN_W];
  assign rd_code = rd_data_r[CODE_W-1:0];

  assign load_len  = (in_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_code_length;
  assign loaded_m1 = loaded_r - LOAD_W'(1);
  assign total_sum = {1'b0, bit_total_r} + (TOTAL_W + 1)'(rd_len);

  // shifter: top byte of the accumulator
  assign emit_shamt   = cnt_r - CNT_W'(BYTE_BITS);
  assign emit_shifted = acc_r >> emit_shamt;
  assign flush_byte   = BYTE_BITS'({1'b0, pend_val_r} << (4'(BYTE_BITS) - {1'b0, pend_cnt_r}));

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[addr_r];
    idx_r     <= addr_r;
  end

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    addr_nxt      = addr_r;
    sym_nxt       = sym_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    pend_val_nxt  = pend_val_r;
    pend_cnt_nxt  = pend_cnt_r;
    bit_total_nxt = bit_total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_has_nxt   = out_has_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = loaded_r[IDX_W-1:0];
    wr_data       = {in_symbol, load_len, in_code_value};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_LOAD: begin
              if (loaded_r < LOAD_W'(TABLE_ENTRIES)) begin
                wr_en      = 1'b1;
                loaded_nxt = loaded_r + LOAD_W'(1);
              end
            end
            MODE_ENCODE: begin
              if (loaded_r != '0) begin
                sym_nxt   = in_symbol;
                addr_nxt  = loaded_m1[IDX_W-1:0];
                state_nxt = ST_FETCH;
              end
            end
            MODE_FLUSH: begin
              state_nxt = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (addr_r != '0) begin
          addr_nxt = addr_r - IDX_W'(1);
        end
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (addr_r != '0) begin
          addr_nxt = addr_r - IDX_W'(1);
        end
        // entry 0 doubles as the no-match fallback
        if (rd_sym == sym_r || idx_r == '0) begin
          acc_nxt = (ACC_W'(pend_val_r) << rd_len)
                  | (ACC_W'(rd_code) & ~({ACC_W{1'b1}} << rd_len));
          cnt_nxt = CNT_W'(pend_cnt_r) + CNT_W'(rd_len);
          bit_total_nxt = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cnt_r < CNT_W'(BYTE_BITS)) begin
          pend_val_nxt = PEND_W'(acc_r) & ~({PEND_W{1'b1}} << cnt_r);
          pend_cnt_nxt = PCNT_W'(cnt_r);
          state_nxt    = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_shifted[BYTE_BITS-1:0];
          out_has_nxt   = 1'b1;
          out_total_nxt = '0;
          out_last_nxt  = (emit_shamt < CNT_W'(BYTE_BITS));
          cnt_nxt       = emit_shamt;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = flush_byte;
          out_has_nxt   = (pend_cnt_r != '0);
          out_total_nxt = bit_total_r;
          out_last_nxt  = 1'b1;
          pend_val_nxt  = '0;
          pend_cnt_nxt  = '0;
          bit_total_nxt = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      pend_val_r  <= '0;
      pend_cnt_r  <= '0;
      bit_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      pend_val_r  <= pend_val_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      bit_total_r <= bit_total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    sym_r       <= sym_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    out_byte_r  <= out_byte_nxt;
    out_has_r   <= out_has_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_has_byte   = out_has_r;
  assign out_total_bits = out_total_r;
  assign out_last       = out_last_r;

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (LOAD_W'(idx_r) < loaded_r))
    else $error("scan index beyond loaded entries");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= LOAD_W'(TABLE_ENTRIES))
    else $error("table fill count overran");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=> (pend_cnt_r == '0 && bit_total_r == '0))
    else $error("flush left bits pending");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (cnt_r <= CNT_W'(ACC_W)))
    else $error("accumulator count overran");

endmodule

// File: dv/tb_variable_length_code_packer.sv
`timescale 1ns / 1ps

module tb_variable_length_code_packer;
  import vlcp_pkg::*;

  // a smaller table keeps the fill-to-full test near the item budget
  localparam int TABLE_N   = 64;
  localparam int MAX_BITS  = MAX_CODE_BITS_DEF;
  localparam int LEN_CAP   = (MAX_BITS < CODE_W) ? MAX_BITS : CODE_W;
  localparam int HOLD_LEN  = 400;
  localparam int STALL_MAX = 4000;
  localparam int PRINT_MAX = 40;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [BYTE_BITS-1:0] data;
    logic                 has;
    logic [TOTAL_W-1:0]   total;
    logic                 last;
  } packed_out_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode;
  logic [SYM_W-1:0]     in_symbol;
  logic [LEN_W-1:0]     in_code_length;
  logic [CODE_W-1:0]    in_code_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 out_has_byte;
  logic [TOTAL_W-1:0]   out_total_bits;
  logic                 out_last;

  // code table and bit accumulator as the block should hold them
  logic [SYM_W-1:0]   tab_sym  [TABLE_N];
  logic [LEN_W-1:0]   tab_len  [TABLE_N];
  logic [CODE_W-1:0]  tab_code [TABLE_N];
  int                 tab_fill;
  logic [PEND_W-1:0]  acc_bits;
  int                 acc_count;
  logic [TOTAL_W-1:0] stream_bits;

  packed_out_t expected_out[$];
  int unsigned n_err;
  int unsigned stall_cycles;
  bit          steady;
  int          hold_seq;
  int          hold_seen;
  int          hold_left;

  variable_length_code_packer #(
    .TABLE_ENTRIES(TABLE_N),
    .MAX_CODE_BITS(MAX_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_symbol     (in_symbol),
    .in_code_length(in_code_length),
    .in_code_value (in_code_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_has_byte  (out_has_byte),
    .out_total_bits(out_total_bits),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [LEN_W-1:0] cap_length(input logic [LEN_W-1:0] l);
    return (l > LEN_CAP) ? LEN_CAP[LEN_W-1:0] : l;
  endfunction

  function automatic void push_out(input logic [7:0] d, input logic h,
                                   input logic [31:0] t, input logic l);
    packed_out_t r;
    r.data  = d;
    r.has   = h;
    r.total = t;
    r.last  = l;
    expected_out.push_back(r);
  endfunction

  // Works out what one accepted request does to the table and the accumulator.
  function automatic void predict_request(input logic [MODE_W-1:0] mode,
                                          input logic [SYM_W-1:0] sym,
                                          input logic [LEN_W-1:0] len_in,
                                          input logic [CODE_W-1:0] code_in);
    int          idx;
    int          len;
    int          cnt;
    logic [63:0] bits;
    logic [63:0] acc;
    logic [63:0] rest;
    logic [63:0] shifted;
    logic [7:0]  tail;
    case (mode)
      MODE_LOAD: begin
        if (tab_fill < TABLE_N) begin
          tab_sym[tab_fill]  = sym;
          tab_len[tab_fill]  = cap_length(len_in);
          tab_code[tab_fill] = code_in;
          tab_fill++;
        end
      end
      MODE_ENCODE: begin
        if (tab_fill > 0) begin
          idx = 0;
          for (int i = tab_fill - 1; i >= 0; i--) begin
            if (tab_sym[i] == sym) begin
              idx = i;
              break;
            end
          end
          len  = cap_length(tab_len[idx]);
          bits = (len == 0) ? 64'd0 : ({32'd0, tab_code[idx]} & ((64'd1 << len) - 1));
          acc  = ({57'd0, acc_bits} << len) | bits;
          cnt  = acc_count + len;
          if ({1'b0, stream_bits} + len > 33'h0_FFFF_FFFF) stream_bits = '1;
          else stream_bits = stream_bits + len;
          while (cnt >= BYTE_BITS) begin
            shifted = acc >> (cnt - BYTE_BITS);
            cnt -= BYTE_BITS;
            push_out(shifted[7:0], 1'b1, '0, cnt < BYTE_BITS);
          end
          rest      = (cnt == 0) ? 64'd0 : (acc & ((64'd1 << cnt) - 1));
          acc_count = cnt;
          acc_bits  = rest[PEND_W-1:0];
        end
      end
      MODE_FLUSH: begin
        if (acc_count > 0) begin
          tail = {1'b0, acc_bits} << (BYTE_BITS - acc_count);
          push_out(tail, 1'b1, stream_bits, 1'b1);
        end else begin
          push_out(8'd0, 1'b0, stream_bits, 1'b1);
        end
        acc_bits    = '0;
        acc_count   = 0;
        stream_bits = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_err < PRINT_MAX)
      $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    n_err++;
  endtask

  // One request: random gaps with valid low, then hold valid until taken.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                              input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code);
    while (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_symbol      <= sym;
    in_code_length <= len;
    in_code_value  <= code;
    do @(posedge clk); while (!in_ready);
    predict_request(mode, sym, len, code);
  endtask

  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
                            input logic [CODE_W-1:0] code);
    send_request(MODE_LOAD, sym, len, code);
  endtask

  // length and code fields are don't-care here, so they carry noise
  task automatic encode_symbol(input logic [SYM_W-1:0] sym);
    send_request(MODE_ENCODE, sym, LEN_W'($urandom_range(63)), $urandom);
  endtask

  task automatic flush_stream();
    send_request(MODE_FLUSH, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
                 $urandom);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_out.size() != 0);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    if (tab_fill > 0 && $urandom_range(99) < 80)
      return tab_sym[$urandom_range(tab_fill - 1)];
    return SYM_W'($urandom_range(255));
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 15) return LEN_W'($urandom_range(63, 33));
    if (r < 40) return LEN_W'($urandom_range(8, 1));
    return LEN_W'($urandom_range(32, 1));
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic test_empty_table();
    encode_symbol(8'h41);
    flush_stream();
    send_request(MODE_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    send_request(MODE_UNUSED, 8'h00, 6'h00, 32'h0000_0000);
  endtask

  task automatic test_load_and_encode_cases();
    load_entry(8'h00, 6'd3,  32'hFFFF_FFFD);   // only the low three bits count
    load_entry(8'hFF, 6'd32, 32'hFFFF_FFFF);
    load_entry(8'h55, 6'd0,  32'hDEAD_BEEF);
    load_entry(8'hAA, 6'd63, 32'hA5A5_A5A5);   // saturates to the cap
    load_entry(8'h00, 6'd1,  32'h0000_0000);   // shadows the first entry
    load_entry(8'h3C, 6'd7,  32'h0000_005A);
    encode_symbol(8'h3C);                      // seven bits, no byte yet
    encode_symbol(8'hFF);                      // four bytes at once
    encode_symbol(8'h12);                      // no match, falls back to entry 0
    encode_symbol(8'h00);
    encode_symbol(8'h55);
    encode_symbol(8'hAA);
    flush_stream();
    flush_stream();                            // nothing pending
    encode_symbol(8'h3C);
    encode_symbol(8'h00);                      // lands exactly on a byte boundary
    flush_stream();
  endtask

  task automatic test_random_stream();
    int r;
    for (int n = 0; n < 150; n++) begin
      steady = (n >= 50 && n < 100);
      r = $urandom_range(99);
      if (r < 15 && tab_fill < TABLE_N - 20) begin
        load_entry(($urandom_range(1) == 0) ? SYM_W'($urandom_range(15))
                                            : SYM_W'($urandom_range(255)),
                   pick_length(), pick_code());
      end else if (r < 80) begin
        encode_symbol(pick_symbol());
      end else if (r < 92) begin
        flush_stream();
      end else begin
        send_request(MODE_UNUSED, SYM_W'($urandom_range(255)), LEN_W'($urandom_range(63)),
                     $urandom);
      end
    end
    steady = 1'b0;
  endtask

  // receiver stalls while long codes keep coming, so the block backs up
  task automatic test_receiver_hold_off();
    load_entry(8'hE7, 6'd32, $urandom);
    hold_seq++;
    for (int n = 0; n < 30; n++)
      encode_symbol(8'hE7);
    flush_stream();
  endtask

  task automatic test_full_table();
    while (tab_fill < TABLE_N)
      load_entry(SYM_W'($urandom_range(255)), pick_length(), pick_code());
    for (int n = 0; n < 4; n++)
      load_entry(SYM_W'($urandom_range(255)), pick_length(), pick_code());
    for (int n = 0; n < 40; n++) begin
      if (n % 13 == 12) flush_stream();
      else encode_symbol(pick_symbol());
    end
    flush_stream();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = MODE_LOAD;
    in_symbol      = '0;
    in_code_length = '0;
    in_code_value  = '0;
    steady         = 1'b0;
    n_err          = 0;
    tab_fill       = 0;
    acc_bits       = '0;
    acc_count      = 0;
    stream_bits    = '0;
    for (int i = 0; i < TABLE_N; i++) begin
      tab_sym[i]  = '0;
      tab_len[i]  = '0;
      tab_code[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_load_and_encode_cases();
    wait_drained();
    test_random_stream();
    wait_drained();
    test_receiver_hold_off();
    test_full_table();

    wait_drained();
    repeat (TABLE_N + 40) @(posedge clk);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_ready = 1'b0;
    hold_seq  = 0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    packed_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected result", {24'd0, out_byte}, '0);
      end else begin
        want = expected_out.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", {24'd0, out_byte}, {24'd0, want.data});
        if (out_has_byte !== want.has) report_mismatch("has_byte", {31'd0, out_has_byte}, {31'd0, want.has});
        if (out_total_bits !== want.total) report_mismatch("total_bits", out_total_bits, want.total);
        if (out_last !== want.last) report_mismatch("last", {31'd0, out_last}, {31'd0, want.last});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial stall_cycles = 0;

endmodule
